[rtl/core/gbd_pkg.sv]
// shared types and constants for the gyro bias, dead-band and yaw integrator
package gbd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int YAW_W    = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int SETTLE_W   = 8;
  localparam int DEADBAND_W = 15;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 2'd1;

  localparam logic [SETTLE_W-1:0]   SETTLE_RESET   = 8'd32;
  localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 15'd65;

  // per-sample control shared by the three axis lanes
  typedef struct packed {
    logic take;        // sample transfer this cycle
    logic accumulate;  // add sample into bias sum
    logic finalize;    // turn sum into mean offset, correct this sample
    logic cal_done;    // offsets already final
  } lane_ctrl_t;

  // stage loads for the merge unit
  typedef struct packed {
    logic adv2;        // valid item moves into product stage
    logic adv3;        // valid item moves into output register
    logic ready_s2;    // product stage item is calibrated
  } yaw_ctrl_t;

endpackage

[rtl/core/gbd_lane.sv]
// one axis lane: bias accumulation, mean offset and offset correction
module gbd_lane #(
  parameter int CAL_LOG2 = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  gbd_pkg::lane_ctrl_t                 ctrl,
  input  logic signed [gbd_pkg::SAMPLE_W-1:0] sample,
  output logic signed [gbd_pkg::SAMPLE_W-1:0] rate
);

  // room for every sample the phase counter can let into the sum, even when
  // the settle count moves during the window
  localparam int SUM_W = gbd_pkg::SAMPLE_W + gbd_pkg::SETTLE_W + CAL_LOG2 + 1;
  localparam logic [SUM_W-1:0] ROUND = (SUM_W'(1) << CAL_LOG2) - SUM_W'(1);

  logic signed [SUM_W-1:0] bias;
  logic signed [SUM_W-1:0] sample_ext;
  logic signed [SUM_W-1:0] biased;
  logic signed [SUM_W-1:0] mean;
  logic signed [gbd_pkg::SAMPLE_W-1:0] offset;

  assign sample_ext = {{(SUM_W-gbd_pkg::SAMPLE_W){sample[gbd_pkg::SAMPLE_W-1]}}, sample};
  // truncate toward zero: bias negative sums up before the arithmetic shift
  assign biased = bias + (bias[SUM_W-1] ? ROUND : '0);
  assign mean   = biased >>> CAL_LOG2;
  assign offset = ctrl.finalize ? mean[gbd_pkg::SAMPLE_W-1:0] : bias[gbd_pkg::SAMPLE_W-1:0];

  always_comb begin
    if (ctrl.finalize || ctrl.cal_done) begin
      rate = sample - offset;
    end else begin
      rate = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bias <= '0;
    end else if (ctrl.take) begin
      if (ctrl.accumulate) begin
        bias <= bias + sample_ext;
      end else if (ctrl.finalize) begin
        bias <= mean;
      end
    end
  end

endmodule

[rtl/core/gbd_yaw.sv]
// merge unit: z dead-band, rate times time step, 48-bit yaw accumulator
module gbd_yaw (
  input  logic                                  clk,
  input  logic                                  rst,
  input  gbd_pkg::yaw_ctrl_t                    ctrl,
  input  logic signed [gbd_pkg::SAMPLE_W-1:0]   rate_z_s1,
  input  logic [gbd_pkg::SAMPLE_W-1:0]          elapsed_s1,
  input  logic [gbd_pkg::DEADBAND_W-1:0]        deadband,
  output logic signed [gbd_pkg::SAMPLE_W-1:0]   rate_z,
  output logic signed [gbd_pkg::YAW_W-1:0]      yaw_accum
);

  localparam int PROD_W = 2 * gbd_pkg::SAMPLE_W + 1;

  logic signed [gbd_pkg::SAMPLE_W:0]   z_wide;
  logic signed [gbd_pkg::SAMPLE_W:0]   z_mag;
  logic signed [gbd_pkg::SAMPLE_W-1:0] z_db;
  logic signed [gbd_pkg::SAMPLE_W-1:0] z_s2;
  logic signed [PROD_W-1:0]            prod;
  logic signed [gbd_pkg::YAW_W-1:0]    yaw_total;
  logic signed [gbd_pkg::YAW_W-1:0]    yaw_total_next;

  // magnitude in 17 bits so the most negative rate never falls in the band
  assign z_wide = {rate_z_s1[gbd_pkg::SAMPLE_W-1], rate_z_s1};
  assign z_mag  = z_wide[gbd_pkg::SAMPLE_W] ? -z_wide : z_wide;
  assign z_db   = ($unsigned(z_mag) <= {2'b00, deadband}) ? '0 : rate_z_s1;

  assign yaw_total_next = yaw_total + {{(gbd_pkg::YAW_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (ctrl.adv2) begin
      z_s2 <= z_db;
      prod <= z_db * $signed({1'b0, elapsed_s1});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_total <= '0;
    end else if (ctrl.adv3 && ctrl.ready_s2) begin
      yaw_total <= yaw_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv3) begin
      rate_z    <= z_s2;
      yaw_accum <= ctrl.ready_s2 ? yaw_total_next : '0;
    end
  end

endmodule

[rtl/core/gyro_bias_deadband_yaw_integrator.sv]
// top level: gyro bias calibration, z dead-band and yaw integration
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  sample  | sample_valid, sample_stall, gyro_x/y/z, | in (stall out)
//          | elapsed_ms                            |
//  result  | result_valid, result_stall, ready_res,| out (stall in)
//          | rate_x/y/z, yaw_accum                 |
//  config  | cfg_valid, cfg_ready, cfg_index,      | in (ready out)
//          | cfg_data                              |
//
// one sample per cycle unless result stalls; stage 1, stage 2, output register
// the yaw accumulator add in the output stage is a feedback loop
// sync reset clears calibration, sums, yaw; presets config; no clearing pass
// each stage holds its item while the stage ahead is full and stalled, so
// empty stages behind a stalled result still take new samples
module gyro_bias_deadband_yaw_integrator #(
  parameter int CAL_LOG2 = 5
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // sample channel
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  logic signed [gbd_pkg::SAMPLE_W-1:0]   gyro_x,
  input  logic signed [gbd_pkg::SAMPLE_W-1:0]   gyro_y,
  input  logic signed [gbd_pkg::SAMPLE_W-1:0]   gyro_z,
  input  logic [gbd_pkg::SAMPLE_W-1:0]          elapsed_ms,
  // result channel
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic                                  ready_res,
  output logic signed [gbd_pkg::SAMPLE_W-1:0]   rate_x,
  output logic signed [gbd_pkg::SAMPLE_W-1:0]   rate_y,
  output logic signed [gbd_pkg::SAMPLE_W-1:0]   rate_z,
  output logic signed [gbd_pkg::YAW_W-1:0]      yaw_accum,
  // configuration channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [gbd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [gbd_pkg::CFG_DATA_W-1:0]        cfg_data
);

  // phase counter spans settle count plus the summing window
  localparam int PHASE_W = gbd_pkg::SETTLE_W + CAL_LOG2 + 1;
  localparam logic [PHASE_W-1:0] CAL_N = PHASE_W'(1) << CAL_LOG2;

  // configuration registers
  logic [gbd_pkg::SETTLE_W-1:0]   settle_count;
  logic [gbd_pkg::DEADBAND_W-1:0] deadband;

  // calibration control
  logic [PHASE_W-1:0] phase_count;
  logic [PHASE_W-1:0] settle_ext;
  logic [PHASE_W-1:0] summed;
  logic               cal_done;
  logic               settling;
  logic               in_window;
  gbd_pkg::lane_ctrl_t lane_ctrl;

  // pipeline handshake
  logic take;
  logic en1, en2, en3;
  logic v1, v2;
  gbd_pkg::yaw_ctrl_t yaw_ctrl;

  // lane outputs and stage registers
  logic signed [gbd_pkg::SAMPLE_W-1:0] lane_x, lane_y, lane_z;
  logic                                ready1, ready2;
  logic signed [gbd_pkg::SAMPLE_W-1:0] rx1, ry1, rz1;
  logic signed [gbd_pkg::SAMPLE_W-1:0] rx2, ry2;
  logic [gbd_pkg::SAMPLE_W-1:0]        el1;

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_count <= gbd_pkg::SETTLE_RESET;
      deadband     <= gbd_pkg::DEADBAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == gbd_pkg::CFG_SETTLE) begin
        settle_count <= cfg_data[gbd_pkg::SETTLE_W-1:0];
      end else if (cfg_index == gbd_pkg::CFG_DEADBAND) begin
        deadband <= cfg_data[gbd_pkg::DEADBAND_W-1:0];
      end
    end
  end

  // stage enables: a stage loads when empty or when the stage ahead moves
  assign en3          = !result_valid || !result_stall;
  assign en2          = !v2 || en3;
  assign en1          = !v1 || en2;
  assign sample_stall = !en1;
  assign take         = sample_valid && !sample_stall;

  // settle, then sum the window, then finalize on the next sample
  assign settle_ext = {{(PHASE_W-gbd_pkg::SETTLE_W){1'b0}}, settle_count};
  assign settling   = phase_count < settle_ext;
  assign summed     = phase_count - settle_ext;
  assign in_window  = summed < CAL_N;

  assign lane_ctrl.take       = take;
  assign lane_ctrl.accumulate = !cal_done && !settling && in_window;
  assign lane_ctrl.finalize   = !cal_done && !settling && !in_window;
  assign lane_ctrl.cal_done   = cal_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= '0;
      cal_done    <= 1'b0;
    end else if (take && !cal_done) begin
      if (lane_ctrl.finalize) begin
        cal_done <= 1'b1;
      end else begin
        phase_count <= phase_count + PHASE_W'(1);
      end
    end
  end

  // three axis lanes in parallel
  gbd_lane #(.CAL_LOG2(CAL_LOG2)) u_lane_x (
    .clk(clk), .rst(rst), .ctrl(lane_ctrl), .sample(gyro_x), .rate(lane_x)
  );
  gbd_lane #(.CAL_LOG2(CAL_LOG2)) u_lane_y (
    .clk(clk), .rst(rst), .ctrl(lane_ctrl), .sample(gyro_y), .rate(lane_y)
  );
  gbd_lane #(.CAL_LOG2(CAL_LOG2)) u_lane_z (
    .clk(clk), .rst(rst), .ctrl(lane_ctrl), .sample(gyro_z), .rate(lane_z)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= take;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        result_valid <= v2;
      end
    end
  end

  // stage 1: corrected rates straight from the lanes
  always_ff @(posedge clk) begin
    if (take) begin
      ready1 <= lane_ctrl.finalize || cal_done;
      rx1    <= lane_x;
      ry1    <= lane_y;
      rz1    <= lane_z;
      el1    <= elapsed_ms;
    end
  end

  // stage 2: x and y ride along with the product stage
  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      ready2 <= ready1;
      rx2    <= rx1;
      ry2    <= ry1;
    end
  end

  // stage 3: output register
  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      ready_res <= ready2;
      rate_x    <= rx2;
      rate_y    <= ry2;
    end
  end

  assign yaw_ctrl.adv2     = en2 && v1;
  assign yaw_ctrl.adv3     = en3 && v2;
  assign yaw_ctrl.ready_s2 = ready2;

  // merge: dead-band, multiply, yaw accumulate
  gbd_yaw u_yaw (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (yaw_ctrl),
    .rate_z_s1  (rz1),
    .elapsed_s1 (el1),
    .deadband   (deadband),
    .rate_z     (rate_z),
    .yaw_accum  (yaw_accum)
  );

endmodule

[rtl/core/gbd_checker.sv]
// port-level checker for the gyro bias, dead-band and yaw integrator, with bind
module gbd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                result_valid,
  input logic                                result_stall,
  input logic                                ready_res,
  input logic signed [gbd_pkg::SAMPLE_W-1:0] rate_x,
  input logic signed [gbd_pkg::SAMPLE_W-1:0] rate_y,
  input logic signed [gbd_pkg::SAMPLE_W-1:0] rate_z,
  input logic signed [gbd_pkg::YAW_W-1:0]    yaw_accum
);

  logic                             seen_ready;
  logic signed [gbd_pkg::YAW_W-1:0] last_yaw;
  logic                             out_xfer;

  assign out_xfer = result_valid && !result_stall;

  // track the last calibrated yaw that was transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_ready <= 1'b0;
      last_yaw   <= '0;
    end else if (out_xfer && ready_res) begin
      seen_ready <= 1'b1;
      last_yaw   <= yaw_accum;
    end
  end

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(ready_res) &&
      $stable(rate_x) && $stable(rate_y) && $stable(rate_z) && $stable(yaw_accum))
    else $error("stalled result changed");

  // uncalibrated results are all zero
  a_zero_before_cal: assert property (@(posedge clk) disable iff (rst)
    result_valid && !ready_res |->
      rate_x == '0 && rate_y == '0 && rate_z == '0 && yaw_accum == '0)
    else $error("uncalibrated result not zero");

  // calibration never undoes itself
  a_ready_sticks: assert property (@(posedge clk) disable iff (rst)
    result_valid && seen_ready |-> ready_res)
    else $error("ready dropped after calibration");

  // zero z rate leaves the yaw total alone
  a_yaw_still: assert property (@(posedge clk) disable iff (rst)
    result_valid && ready_res && seen_ready && rate_z == '0 |-> yaw_accum == last_yaw)
    else $error("yaw moved with zero z rate");

endmodule

bind gyro_bias_deadband_yaw_integrator gbd_checker u_gbd_checker (.*);
